>>> rtl/aet_pkg.sv
// Shared types, character codes and constants of the expression tokenizer.
// No dependencies; every other file imports this package.
package aet_pkg;

	localparam int CHAR_W      = 8;
	localparam int INT_W       = 32;
	localparam int FRAC_W      = 32;
	localparam int FRAC_ACC_W  = 30;
	localparam int CNT_W       = 4;
	localparam int FRAC_DIGITS = 9;
	localparam int DIV_STEP_W  = 6;

	// scan mode codes
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_INT  = 2'd1;
	localparam logic [1:0] MODE_FRAC = 2'd2;

	// token kinds
	localparam logic [1:0] KIND_NUM   = 2'd0;
	localparam logic [1:0] KIND_PAREN = 2'd1;
	localparam logic [1:0] KIND_OP    = 2'd2;
	localparam logic [1:0] KIND_END   = 2'd3;

	// operator priorities
	localparam logic [1:0] PRI_NONE = 2'd0;
	localparam logic [1:0] PRI_ADD  = 2'd1;
	localparam logic [1:0] PRI_MUL  = 2'd2;
	localparam logic [1:0] PRI_POW  = 2'd3;

	// character codes
	localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
	localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
	localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;

	localparam logic [INT_W-1:0] INT_LIMIT = {INT_W{1'b1}};

	// commands from the controller to the datapath
	typedef struct packed {
		logic capture;     // register the accepted character
		logic digit;       // fold a digit into the pending number
		logic start_num;   // begin a number with its first integer digit
		logic enter_frac;  // switch the pending number to its fraction
		logic div_start;   // start the fraction conversion
		logic load_num;    // put the number token in the output register
		logic load_chr;    // put the character token in the output register
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic [1:0] mode;
		logic       is_digit;
		logic       is_dot;
		logic       is_space;
		logic       div_busy;
		logic       out_free;
	} status_t;

	// 10^n for n = 0..9, fits in 30 bits
	function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [CNT_W-1:0] n);
		logic [FRAC_ACC_W-1:0] p;
		case (n)
			4'd0:    p = 30'd1;
			4'd1:    p = 30'd10;
			4'd2:    p = 30'd100;
			4'd3:    p = 30'd1000;
			4'd4:    p = 30'd10000;
			4'd5:    p = 30'd100000;
			4'd6:    p = 30'd1000000;
			4'd7:    p = 30'd10000000;
			4'd8:    p = 30'd100000000;
			4'd9:    p = 30'd1000000000;
			default: p = 30'd1;
		endcase
		return p;
	endfunction

endpackage

>>> rtl/aet_char_if.sv
// Character input channel: valid/ready handshake with one character per beat.
// Depends on aet_pkg.
interface aet_char_if import aet_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;

	modport source(output valid, output char_code, input ready);
	modport sink(input valid, input char_code, output ready);
endinterface

>>> rtl/aet_tok_if.sv
// Token output channel: valid/ready handshake with one token per beat.
// Depends on aet_pkg.
interface aet_tok_if import aet_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        token_kind;
	logic [INT_W-1:0]  int_part;
	logic [FRAC_W-1:0] frac_part;
	logic              overflowed;
	logic [CHAR_W-1:0] symbol;
	logic [1:0]        priority_res;
	logic              last_of_run;

	modport source(output valid, output token_kind, output int_part, output frac_part,
		output overflowed, output symbol, output priority_res, output last_of_run,
		input ready);
	modport sink(input valid, input token_kind, input int_part, input frac_part,
		input overflowed, input symbol, input priority_res, input last_of_run,
		output ready);
endinterface

>>> rtl/aet_div.sv
// Restoring divider for the fraction: floor(F * 2^32 / 10^n), one quotient bit a cycle.
// Depends on aet_pkg (pow10, widths).
module aet_div import aet_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [FRAC_ACC_W-1:0] numer,
	input  logic [CNT_W-1:0]      digits,
	output logic                  busy,
	output logic [FRAC_W-1:0]     quot
);

	logic [FRAC_ACC_W-1:0] rem_q;
	logic [FRAC_ACC_W-1:0] div_q;
	logic [FRAC_W-1:0]     quot_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic [FRAC_ACC_W:0]   trial;
	logic [FRAC_ACC_W:0]   diff;
	logic                  ge;

	// remainder stays below the divisor, so one spare bit covers the shift
	assign trial = {rem_q, 1'b0};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (start) begin
			step_q <= DIV_STEP_W'(FRAC_W);
		end else if (step_q != '0) begin
			step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= numer;
			div_q  <= pow10(digits);
			quot_q <= '0;
		end else if (step_q != '0) begin
			rem_q  <= ge ? diff[FRAC_ACC_W-1:0] : trial[FRAC_ACC_W-1:0];
			quot_q <= {quot_q[FRAC_W-2:0], ge};
		end
	end

	assign busy = step_q != '0;
	assign quot = quot_q;

endmodule

>>> rtl/aet_dp.sv
// Tokenizer datapath: character register, number accumulators, fraction
// divider and the token output register. Depends on aet_pkg and aet_div.
module aet_dp import aet_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output status_t           sts,
	input  logic [CHAR_W-1:0] in_char,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [1:0]        out_kind,
	output logic [INT_W-1:0]  out_int,
	output logic [FRAC_W-1:0] out_frac,
	output logic              out_ovf,
	output logic [CHAR_W-1:0] out_sym,
	output logic [1:0]        out_pri,
	output logic              out_last
);

	logic [CHAR_W-1:0]     char_q;
	logic [1:0]            mode_q;
	logic [INT_W-1:0]      int_q;
	logic                  sat_q;
	logic [FRAC_ACC_W-1:0] frac_q;
	logic [CNT_W-1:0]      cnt_q;

	logic                  out_valid_q;
	logic [1:0]            kind_q;
	logic [INT_W-1:0]      int_out_q;
	logic [FRAC_W-1:0]     frac_out_q;
	logic                  ovf_q;
	logic [CHAR_W-1:0]     sym_q;
	logic [1:0]            pri_q;
	logic                  last_q;

	logic [3:0]            dval;
	logic [INT_W+3:0]      int_x10;
	logic [FRAC_ACC_W-1:0] frac_x10;
	logic                  is_digit, is_dot, is_space, is_paren;
	logic [1:0]            chr_pri;
	logic                  div_busy;
	logic [FRAC_W-1:0]     div_quot;
	logic                  out_free;

	assign dval     = char_q[3:0];
	assign is_digit = char_q inside {[CH_ZERO:CH_NINE]};
	assign is_dot   = char_q == CH_DOT;
	assign is_space = char_q == CH_SPACE;
	assign is_paren = char_q inside {CH_LPAREN, CH_RPAREN};
	assign out_free = !out_valid_q || out_ready;

	// times ten as shift and add
	assign int_x10  = ({4'b0, int_q} << 3) + ({4'b0, int_q} << 1) + {{INT_W{1'b0}}, dval};
	assign frac_x10 = (frac_q << 3) + (frac_q << 1) + {{(FRAC_ACC_W-4){1'b0}}, dval};

	always_comb begin
		case (char_q)
			CH_CARET:          chr_pri = PRI_POW;
			CH_STAR, CH_SLASH: chr_pri = PRI_MUL;
			CH_PLUS, CH_MINUS: chr_pri = PRI_ADD;
			default:           chr_pri = PRI_NONE;
		endcase
	end

	aet_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.numer  (frac_q),
		.digits (cnt_q),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_q <= CH_NUL;
			mode_q <= MODE_IDLE;
			int_q  <= '0;
			sat_q  <= 1'b0;
			frac_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd.capture) begin
				char_q <= in_char;
			end
			if (cmd.digit) begin
				if (mode_q == MODE_INT) begin
					if (sat_q || int_x10[INT_W+3:INT_W] != '0) begin
						int_q <= INT_LIMIT;
						sat_q <= 1'b1;
					end else begin
						int_q <= int_x10[INT_W-1:0];
					end
				end else if (cnt_q < CNT_W'(FRAC_DIGITS)) begin
					frac_q <= frac_x10;
					cnt_q  <= cnt_q + 1'b1;
				end
			end
			if (cmd.start_num) begin
				int_q  <= {{(INT_W-4){1'b0}}, dval};
				mode_q <= MODE_INT;
			end
			if (cmd.enter_frac) begin
				mode_q <= MODE_FRAC;
			end
			if (cmd.load_num) begin
				// a dot that ends a number opens the fraction of the next one
				int_q  <= '0;
				sat_q  <= 1'b0;
				frac_q <= '0;
				cnt_q  <= '0;
				mode_q <= is_dot ? MODE_FRAC : MODE_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_num || cmd.load_chr) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_num) begin
			kind_q     <= KIND_NUM;
			int_out_q  <= int_q;
			frac_out_q <= div_quot;
			ovf_q      <= sat_q;
			sym_q      <= CH_NUL;
			pri_q      <= PRI_NONE;
			last_q     <= is_dot || is_space;
		end else if (cmd.load_chr) begin
			kind_q     <= (char_q == CH_NUL) ? KIND_END : (is_paren ? KIND_PAREN : KIND_OP);
			int_out_q  <= '0;
			frac_out_q <= '0;
			ovf_q      <= 1'b0;
			sym_q      <= char_q;
			pri_q      <= (is_paren || char_q == CH_NUL) ? PRI_NONE : chr_pri;
			last_q     <= 1'b1;
		end
	end

	assign sts.mode     = mode_q;
	assign sts.is_digit = is_digit;
	assign sts.is_dot   = is_dot;
	assign sts.is_space = is_space;
	assign sts.div_busy = div_busy;
	assign sts.out_free = out_free;

	assign out_valid = out_valid_q;
	assign out_kind  = kind_q;
	assign out_int   = int_out_q;
	assign out_frac  = frac_out_q;
	assign out_ovf   = ovf_q;
	assign out_sym   = sym_q;
	assign out_pri   = pri_q;
	assign out_last  = last_q;

endmodule

>>> rtl/aet_ctrl.sv
// Tokenizer controller: sequences accept, decode, fraction division and token loads.
// Depends on aet_pkg.
module aet_ctrl import aet_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t sts,
	output cmd_t    cmd
);

	localparam logic [2:0] S_IN  = 3'd0;
	localparam logic [2:0] S_DEC = 3'd1;
	localparam logic [2:0] S_DIV = 3'd2;
	localparam logic [2:0] S_NUM = 3'd3;
	localparam logic [2:0] S_CHR = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	assign in_ready = state_q == S_IN;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			S_IN: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nx    = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.mode != MODE_IDLE) begin
					if (sts.is_digit) begin
						cmd.digit = 1'b1;
						state_nx  = S_IN;
					end else if (sts.is_dot && sts.mode == MODE_INT) begin
						cmd.enter_frac = 1'b1;
						state_nx       = S_IN;
					end else begin
						cmd.div_start = 1'b1;
						state_nx      = S_DIV;
					end
				end else if (sts.is_space) begin
					state_nx = S_IN;
				end else if (sts.is_digit) begin
					cmd.start_num = 1'b1;
					state_nx      = S_IN;
				end else if (sts.is_dot) begin
					cmd.enter_frac = 1'b1;
					state_nx       = S_IN;
				end else begin
					state_nx = S_CHR;
				end
			end
			S_DIV: begin
				if (!sts.div_busy) begin
					state_nx = S_NUM;
				end
			end
			S_NUM: begin
				if (sts.out_free) begin
					cmd.load_num = 1'b1;
					state_nx     = (sts.is_dot || sts.is_space) ? S_IN : S_CHR;
				end
			end
			S_CHR: begin
				if (sts.out_free) begin
					cmd.load_chr = 1'b1;
					state_nx     = S_IN;
				end
			end
			default: begin
				state_nx = S_IN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IN;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

>>> rtl/arithmetic_expression_tokenizer_top.sv
// Arithmetic expression tokenizer, top level.
// Depends on aet_pkg, aet_char_if, aet_tok_if, aet_ctrl and aet_dp.
//
// Usage:
//   chars  (sink)   one character beat per accepted valid/ready pair.
//   tokens (source) one token beat per accepted valid/ready pair.
// Digits, the first dot of a number and spaces between tokens are each
// taken as a beat in S_IN and decoded in S_DEC. A character that ends a
// number starts the fraction conversion, a restoring divider that yields
// one quotient bit a cycle; the number token is loaded in S_NUM once the
// divider is done and the output register is free, and unless the ending
// character is a dot or a space its own token follows from S_CHR. Plain
// operator, paren and end tokens go through S_IN, S_DEC and S_CHR.
// The token output register holds a finished token while the controller
// returns to take the next character; the tokenizer only waits on a stalled
// receiver when it has a new token to load. Hold tokens.ready low and the
// current token stays put until it is taken.
// Reset (arst_n low) drops any pending number, clears the output register
// and returns the scanner to idle. A NUL character flushes a pending number
// and emits an end token, leaving the scanner idle again.
module arithmetic_expression_tokenizer_top import aet_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	aet_char_if.sink   chars,
	aet_tok_if.source  tokens
);

	cmd_t    cmd;
	status_t sts;

	// controller: state machine only, no payload
	aet_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chars.valid),
		.in_ready (chars.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: accumulators, divider and token register
	aet_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_char   (chars.char_code),
		.out_ready (tokens.ready),
		.out_valid (tokens.valid),
		.out_kind  (tokens.token_kind),
		.out_int   (tokens.int_part),
		.out_frac  (tokens.frac_part),
		.out_ovf   (tokens.overflowed),
		.out_sym   (tokens.symbol),
		.out_pri   (tokens.priority_res),
		.out_last  (tokens.last_of_run)
	);

endmodule

>>> tb/tb_top.sv
// Self-checking bench for the arithmetic expression tokenizer.
// Depends on aet_pkg, aet_char_if, aet_tok_if and arithmetic_expression_tokenizer_top.
// Characters go in with random gaps, tokens come out under random stalls, and each is checked.
module tb_top;
	import aet_pkg::*;

	localparam int CHAR_TARGET    = 1800;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 400;
	localparam int SETTLE_CYCLES  = 80;
	localparam int PHASE_CHARS    = 200;

	// One token as it appears on the output channel.
	typedef struct packed {
		logic [1:0]        kind;
		logic [INT_W-1:0]  int_part;
		logic [FRAC_W-1:0] frac_part;
		logic              overflowed;
		logic [CHAR_W-1:0] symbol;
		logic [1:0]        priority_res;
		logic              last_of_run;
	} token_t;

	// Tracks the scanner state of the block, turns each accepted character
	// into the tokens it should cause and checks the tokens that come out.
	class token_tracker;
		logic [1:0]  mode;
		logic [63:0] int_acc;
		logic        saturated;
		logic [63:0] frac_acc;
		int unsigned frac_cnt;
		token_t      pending_tokens[$];
		int          errors;

		function new();
			mode = MODE_IDLE;
			clear_number();
			errors = 0;
		endfunction

		function void clear_number();
			int_acc = 0;
			saturated = 1'b0;
			frac_acc = 0;
			frac_cnt = 0;
		endfunction

		// Fraction as floor(digits * 2^32 / 10^count).
		function token_t number_token();
			token_t t;
			logic [63:0] scale;
			t = '0;
			t.kind = KIND_NUM;
			t.int_part = int_acc[INT_W-1:0];
			t.overflowed = saturated;
			if (frac_cnt > 0) begin
				scale = 1;
				repeat (frac_cnt) scale = scale * 10;
				t.frac_part = 32'((frac_acc << 32) / scale);
			end
			return t;
		endfunction

		function token_t char_token(logic [CHAR_W-1:0] c);
			token_t t;
			t = '0;
			if (c == CH_NUL) begin
				t.kind = KIND_END;
			end else if (c == CH_LPAREN || c == CH_RPAREN) begin
				t.kind = KIND_PAREN;
				t.symbol = c;
			end else begin
				t.kind = KIND_OP;
				t.symbol = c;
				if (c == CH_CARET)
					t.priority_res = PRI_POW;
				else if (c == CH_STAR || c == CH_SLASH)
					t.priority_res = PRI_MUL;
				else if (c == CH_PLUS || c == CH_MINUS)
					t.priority_res = PRI_ADD;
				else
					t.priority_res = PRI_NONE;
			end
			return t;
		endfunction

		function void note_char(logic [CHAR_W-1:0] c);
			logic        is_digit;
			logic [63:0] d;
			logic [63:0] v;
			token_t      t;
			is_digit = (c >= CH_ZERO && c <= CH_NINE);
			d = 64'(c) - 64'(CH_ZERO);
			if (mode != MODE_IDLE) begin
				if (is_digit) begin
					if (mode == MODE_INT) begin
						v = int_acc * 10 + d;
						if (saturated || v > 64'(INT_LIMIT)) begin
							int_acc = 64'(INT_LIMIT);
							saturated = 1'b1;
						end else begin
							int_acc = v;
						end
					end else if (frac_cnt < FRAC_DIGITS) begin
						frac_acc = frac_acc * 10 + d;
						frac_cnt++;
					end
					return;
				end
				if (c == CH_DOT && mode == MODE_INT) begin
					mode = MODE_FRAC;
					return;
				end
				// the number ends here
				t = number_token();
				clear_number();
				mode = MODE_IDLE;
				if (c == CH_DOT || c == CH_SPACE) begin
					// a second dot opens a new number already in its fraction
					if (c == CH_DOT)
						mode = MODE_FRAC;
					t.last_of_run = 1'b1;
					pending_tokens.push_back(t);
					return;
				end
				t.last_of_run = 1'b0;
				pending_tokens.push_back(t);
			end
			if (c == CH_SPACE)
				return;
			if (is_digit) begin
				int_acc = d;
				mode = MODE_INT;
				return;
			end
			if (c == CH_DOT) begin
				mode = MODE_FRAC;
				return;
			end
			t = char_token(c);
			t.last_of_run = 1'b1;
			pending_tokens.push_back(t);
			if (c == CH_NUL) begin
				mode = MODE_IDLE;
				clear_number();
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			end
		endfunction

		function void check_token(token_t got);
			token_t want;
			if (pending_tokens.size() == 0) begin
				errors++;
				$display("%0t: unexpected token, expected none, got kind %0d symbol %0h",
					$time, got.kind, got.symbol);
				return;
			end
			want = pending_tokens.pop_front();
			compare_field("token_kind", 32'(want.kind), 32'(got.kind));
			compare_field("int_part", want.int_part, got.int_part);
			compare_field("frac_part", want.frac_part, got.frac_part);
			compare_field("overflowed", 32'(want.overflowed), 32'(got.overflowed));
			compare_field("symbol", 32'(want.symbol), 32'(got.symbol));
			compare_field("priority_res", 32'(want.priority_res), 32'(got.priority_res));
			compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	aet_char_if chars();
	aet_tok_if  tokens();

	arithmetic_expression_tokenizer_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.tokens (tokens)
	);

	token_tracker tracker;

	int tx_idle_pct  = 0;    // chance in percent that a character beat waits first
	int rx_idle_pct  = 0;    // chance in percent that the sink drops ready
	int hold_request = 0;    // cycles of long hold-off asked of the sink
	int chars_sent   = 0;    // accepted characters
	int quiet_cycles = 0;

	// Period 8: four units high, four low.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap(int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(20, 60);
		return $urandom_range(1, 3);
	endfunction

	// Token sink: decide ready at the falling edge. A long hold-off asked by
	// the stimulus is counted down here, independent of the sender.
	initial begin : token_sink
		int stall_left;
		stall_left = 0;
		tokens.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left == 0)
				stall_left = pick_gap(rx_idle_pct);
			if (stall_left > 0) begin
				tokens.ready = 1'b0;
				stall_left--;
			end else begin
				tokens.ready = 1'b1;
			end
		end
	end

	// Check every token beat at the rising edge.
	always @(posedge clk) begin
		if (arst_n && tokens.valid && tokens.ready)
			tracker.check_token(token_t'{kind: tokens.token_kind, int_part: tokens.int_part,
				frac_part: tokens.frac_part, overflowed: tokens.overflowed,
				symbol: tokens.symbol, priority_res: tokens.priority_res,
				last_of_run: tokens.last_of_run});
	end

	// Watchdog: give up when neither channel moves a beat for too long.
	always @(posedge clk) begin
		if ((chars.valid && chars.ready) || (tokens.valid && tokens.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// Offer one character beat, starting at a falling edge; hold it until the
	// block takes it, record it and drop valid at the next falling edge.
	task automatic send_char(input logic [CHAR_W-1:0] c);
		int gap;
		gap = pick_gap(tx_idle_pct);
		if (gap > 0) begin
			chars.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		chars.valid = 1'b1;
		chars.char_code = c;
		do @(posedge clk); while (!chars.ready);
		tracker.note_char(c);
		chars_sent++;
		@(negedge clk);
		chars.valid = 1'b0;
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	// Nines are favored so the saturation edge and the largest fraction show up.
	task automatic send_digits(input int count);
		repeat (count) begin
			if ($urandom_range(0, 3) == 0)
				send_char(CH_NINE);
			else
				send_char(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
		end
	endtask

	task automatic maybe_space();
		if ($urandom_range(0, 3) == 0)
			send_char(CH_SPACE);
	endtask

	// A number: integer digits (some long enough to saturate, some right at
	// the limit), an optional fraction that may run past nine digits, and
	// now and then a second dot.
	task automatic send_number();
		int          pick;
		int          n_int;
		logic [63:0] val;
		pick = $urandom_range(0, 9);
		n_int = 0;
		if (pick == 0) begin
			val = 64'(INT_LIMIT) - 1 + 64'($urandom_range(0, 2));
			send_string($sformatf("%0d", val));
			n_int = 1;
		end else begin
			n_int = (pick < 3) ? $urandom_range(8, 12) : $urandom_range(0, 4);
			send_digits(n_int);
		end
		if (n_int == 0 || $urandom_range(0, 2) == 0) begin
			send_char(CH_DOT);
			send_digits(($urandom_range(0, 3) == 0) ? $urandom_range(9, 12)
				: $urandom_range(0, 4));
			if ($urandom_range(0, 7) == 0) begin
				send_char(CH_DOT);
				send_digits($urandom_range(0, 3));
			end
		end
	endtask

	function automatic logic [CHAR_W-1:0] pick_operator();
		case ($urandom_range(0, 5))
			0: return CH_CARET;
			1: return CH_STAR;
			2: return CH_SLASH;
			3: return CH_PLUS;
			4: return CH_MINUS;
			default: return CHAR_W'($urandom_range(0, 255));
		endcase
	endfunction

	// A mostly well-formed expression with random content, usually closed by NUL.
	task automatic send_expression();
		int terms;
		int depth;
		terms = $urandom_range(1, 5);
		depth = 0;
		for (int i = 0; i < terms; i++) begin
			if (i > 0) begin
				maybe_space();
				send_char(pick_operator());
			end
			maybe_space();
			if ($urandom_range(0, 3) == 0) begin
				send_char(CH_LPAREN);
				depth++;
			end
			send_number();
			if (depth > 0 && $urandom_range(0, 2) == 0) begin
				maybe_space();
				send_char(CH_RPAREN);
				depth--;
			end
		end
		while (depth > 0) begin
			send_char(CH_RPAREN);
			depth--;
		end
		maybe_space();
		if ($urandom_range(0, 9) != 0)
			send_char(CH_NUL);
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 8))
			send_char(CHAR_W'($urandom_range(0, 255)));
	endtask

	task automatic wait_drained();
		while (tracker.pending_tokens.size() != 0)
			@(negedge clk);
	endtask

	initial begin : stimulus
		int phase;
		int phase_end;
		tracker = new();
		chars.valid = 1'b0;
		chars.char_code = '0;

		// Hold reset, then release it at a falling edge.
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: number ended by a space, lone dot closed by a paren,
		// a second dot, every operator class, a high code and the end token.
		tx_idle_pct = 20;
		rx_idle_pct = 20;
		send_string("(9.5 .)1.2.3*/+-");
		send_char(8'hFF);
		send_char(CH_NUL);
		// saturation followed directly by an operator
		send_string("99999999999^");
		send_char(CH_NUL);

		// Random part, in phases with different idling.
		phase = 0;
		while (chars_sent < CHAR_TARGET) begin
			case (phase % 4)
				0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
				1: begin tx_idle_pct = 30; rx_idle_pct = 30; end
				2: begin tx_idle_pct = 0;  rx_idle_pct = 60; end
				default: begin tx_idle_pct = 60; rx_idle_pct = 10; end
			endcase
			if (phase == 2) begin
				// Long hold-off at the sink while the sender keeps offering
				// operators: the output fills and the input must stall.
				hold_request = LONG_HOLD;
				repeat (30) send_char(pick_operator());
			end
			if (phase == 3) begin
				// Pause the sender until every token is out.
				wait_drained();
			end
			phase_end = chars_sent + PHASE_CHARS;
			while (chars_sent < phase_end && chars_sent < CHAR_TARGET) begin
				if ($urandom_range(0, 9) == 0)
					send_noise();
				else
					send_expression();
			end
			phase++;
		end

		// Drain, then let the divider latency pass before the verdict.
		chars.valid = 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (tracker.errors == 0 && tracker.pending_tokens.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
